@@ hdl/nec_ir_pkg.sv @@
`default_nettype none

package nec_ir_pkg;

  // Decoder phases.
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
  localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
  localparam logic [2:0] PH_BIT_MARK   = 3'd3;
  localparam logic [2:0] PH_BIT_SPACE  = 3'd4;

  // Input operations.
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Interval limits in microseconds; every window is exclusive at both ends.
  localparam logic [15:0] LEAD_MARK_MIN  = 16'd8500;
  localparam logic [15:0] LEAD_MARK_MAX  = 16'd9500;
  localparam logic [15:0] LEAD_SPACE_MIN = 16'd4000;
  localparam logic [15:0] LEAD_SPACE_MAX = 16'd5000;
  localparam logic [15:0] BIT_MARK_MIN   = 16'd400;
  localparam logic [15:0] BIT_MARK_MAX   = 16'd700;
  localparam logic [15:0] BIT_SPACE_MIN  = 16'd400;
  localparam logic [15:0] BIT_SPACE_MAX  = 16'd1800;
  localparam logic [15:0] ONE_SPACE_MIN  = 16'd1000;

  localparam int CODE_W    = 32;
  localparam int TABLE_LEN = 21;
  localparam int KEY_COUNT = 21;
  localparam int SEARCH_N  = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;

  localparam logic [4:0] KEY_MISS = 5'(KEY_COUNT);

  localparam logic [7:0] KEY_TABLE [0:TABLE_LEN-1] = '{
    8'ha2, 8'h62, 8'he2, 8'h22, 8'h02, 8'hc2, 8'he0, 8'ha8, 8'h90, 8'h68, 8'h98,
    8'hb0, 8'h30, 8'h18, 8'h7a, 8'h10, 8'h38, 8'h5a, 8'h42, 8'h4a, 8'h52
  };

  typedef struct packed {
    logic        op;
    logic        edge_rising;
    logic [15:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic              frame_done;
    logic              aborted;
    logic [CODE_W-1:0] frame_code;
    logic [7:0]        command_byte;
    logic [4:0]        key_index;
  } out_item_t;

  // Phase and shift register carried between items.
  typedef struct packed {
    logic [2:0]        phase;
    logic [CODE_W-1:0] code;
  } dec_state_t;

  // The lowest matching position wins, so the scan runs from the top down.
  function automatic logic [4:0] key_lookup(input logic [7:0] cmd);
    logic [4:0] idx;
    idx = KEY_MISS;
    for (int i = SEARCH_N - 1; i >= 0; i--) begin
      if (KEY_TABLE[i] == cmd) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hdl/nec_ir_step.sv @@
`default_nettype none

module nec_ir_step #(
  parameter int FRAME_BITS = 32,
  parameter int CNT_W      = 5
) (
  input  nec_ir_pkg::in_item_t   item,
  input  nec_ir_pkg::dec_state_t cur,
  input  logic [CNT_W-1:0]       cnt,
  output nec_ir_pkg::dec_state_t nxt,
  output logic [CNT_W-1:0]       cnt_nxt,
  output nec_ir_pkg::out_item_t  result
);
  import nec_ir_pkg::*;

  logic [2:0]       phase_eff;
  logic             want_rising;
  logic [CNT_W:0]   count;
  logic [CODE_W-1:0] shifted;
  logic [15:0]      t;

  assign t       = item.elapsed_us;
  assign count   = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
  assign shifted = {cur.code[CODE_W-2:0], (t > ONE_SPACE_MIN)};

  always_comb begin
    // Unused phase codes behave as idle.
    phase_eff   = (cur.phase > PH_BIT_SPACE) ? PH_IDLE : cur.phase;
    want_rising = (phase_eff == PH_LEAD_MARK) || (phase_eff == PH_BIT_MARK);

    nxt.phase           = phase_eff;
    nxt.code            = cur.code;
    cnt_nxt             = cnt;
    result.frame_done   = 1'b0;
    result.aborted      = 1'b0;
    result.command_byte = 8'd0;
    result.key_index    = KEY_MISS;

    if (item.op == OP_TIMEOUT) begin
      result.aborted = (phase_eff != PH_IDLE);
      nxt.phase      = PH_IDLE;
    end else if (item.edge_rising == want_rising) begin
      unique case (phase_eff)
        PH_IDLE: begin
          cnt_nxt   = '0;
          nxt.code  = '0;
          nxt.phase = PH_LEAD_MARK;
        end
        PH_LEAD_MARK: begin
          if (t > LEAD_MARK_MIN && t < LEAD_MARK_MAX) begin
            nxt.phase = PH_LEAD_SPACE;
          end else begin
            nxt.phase      = PH_IDLE;
            result.aborted = 1'b1;
          end
        end
        PH_LEAD_SPACE: begin
          if (t > LEAD_SPACE_MIN && t < LEAD_SPACE_MAX) begin
            nxt.phase = PH_BIT_MARK;
          end else begin
            nxt.phase      = PH_IDLE;
            result.aborted = 1'b1;
          end
        end
        PH_BIT_MARK: begin
          if (t > BIT_MARK_MIN && t < BIT_MARK_MAX) begin
            nxt.phase = PH_BIT_SPACE;
          end else begin
            nxt.phase      = PH_IDLE;
            result.aborted = 1'b1;
          end
        end
        default: begin
          if (t > BIT_SPACE_MIN && t < BIT_SPACE_MAX) begin
            nxt.code = shifted;
            if (count >= (CNT_W+1)'(FRAME_BITS)) begin
              result.frame_done   = 1'b1;
              cnt_nxt             = '0;
              nxt.phase           = PH_IDLE;
              result.command_byte = shifted[15:8];
              result.key_index    = key_lookup(shifted[15:8]);
            end else begin
              cnt_nxt   = count[CNT_W-1:0];
              nxt.phase = PH_BIT_MARK;
            end
          end else begin
            nxt.phase      = PH_IDLE;
            result.aborted = 1'b1;
          end
        end
      endcase
    end

    result.frame_code = nxt.code;
  end

endmodule

`default_nettype wire

@@ hdl/nec_ir_frame_decoder.sv @@
// NEC infrared remote frame decoder.
// The input channel (in_valid, in_stall, in_data) carries one event per
// transfer: a receiver edge with its polarity and the microseconds since the
// previous edge, or an interval timer timeout. Every event yields exactly one
// result on the output channel (out_valid, out_stall, out_data): the flags for
// a completed frame or an abort, the current 32-bit code and, on a completed
// frame, its command byte and that byte's position in the key table.
// An event is captured in an input register, decoded combinationally and written
// to the output register, from which its result is offered. One event is taken
// every cycle while the output side keeps up; the decoder state advances only
// when a result moves into the output register.
// When the receiver stalls, the result holds in the output register, one more
// event waits in the input register, and in_stall rises after that.
// Reset clears both registers' valid flags and returns the decoder to idle
// with an empty code and bit count; there is no setup sequence.

`default_nettype none

module nec_ir_frame_decoder #(
  parameter int FRAME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nec_ir_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nec_ir_pkg::out_item_t out_data
);
  import nec_ir_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BITS);

  logic       s1_valid_r;
  in_item_t   s1_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  out_item_t  result;
  logic       out_free;
  logic       advance;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  nec_ir_step #(
    .FRAME_BITS (FRAME_BITS),
    .CNT_W      (CNT_W)
  ) u_step (
    .item    (s1_data_r),
    .cur     (state_r),
    .cnt     (cnt_r),
    .nxt     (state_nxt),
    .cnt_nxt (cnt_nxt),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_IDLE, code: '0};
      cnt_r       <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.frame_done && out_data_r.aborted))
    else $error("frame_done and aborted both set");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.frame_done) |->
      (out_data_r.command_byte == 8'd0 && out_data_r.key_index == KEY_MISS))
    else $error("command or key reported without a completed frame");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.frame_done) |=> (cnt_r == '0 && state_r.phase == PH_IDLE))
    else $error("decoder not idle after a completed frame");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a register stage is empty");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(state_r) && $stable(cnt_r)))
    else $error("decoder state changed without a decoded event");

endmodule

`default_nettype wire
